// File: rtl/plmer_pkg.sv
// Shared types and constants for the peak level meter with entropy generator.
// No dependencies; every other file in rtl/ uses it by scoped names.
`default_nettype none

package plmer_pkg;

    // Sample and calibration sizing.
    localparam int SAMPLE_BITS = 12;
    localparam int CAL_WINDOWS = 16;
    localparam int CAL_SUM_W   = SAMPLE_BITS + $clog2(CAL_WINDOWS);
    localparam int CAL_CNT_W   = $clog2(CAL_WINDOWS + 1);

    // Field widths of the stream words.
    localparam int SAMPLE_W = 12;
    localparam int BOUND_W  = 16;
    localparam int LEVEL_W  = 12;
    localparam int OPCODE_W = 2;

    // Window length register.
    localparam int                 WLEN_W     = 10;
    localparam logic [WLEN_W-1:0]  WLEN_RESET = 10'd200;

    // Linear congruential generator.
    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_INC = 32'd1013904223;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RANDOM  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

    // Result kinds.
    localparam logic RK_LEVEL  = 1'b0;
    localparam logic RK_RANDOM = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_RANDOM,
        CMD_RESTART
    } t_cmd_kind;

    // One decoded command: the argument holds the sample in its low bits
    // or the random bound.
    typedef struct packed {
        t_cmd_kind          kind;
        logic [BOUND_W-1:0] arg;
    } t_cmd;

    typedef struct packed {
        logic               kind;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] baseline;
        logic [BOUND_W-1:0] rnd;
        logic               calibrating;
    } t_result;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SMP_ADD,
        BK_RND_ADD,
        BK_DIV,
        BK_EMIT
    } t_back_state;

endpackage

`default_nettype wire

// File: rtl/peak_level_meter_with_entropy_rng.sv
// Top level of the peak level meter with entropy generator.
// Depends on plmer_pkg, plmer_front, plmer_queue and plmer_back.
//
//  Channel   Dir  Handshake                       Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser opcode, tdata sample and bound
//  m_axis    out  m_axis_tvalid / m_axis_tready   tuser kind, tdata level/baseline/random
//  cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_data window length
//
// A sample word passes through queue pop and multiply, add and result load in the
// back end, and skips the result load when it does not close a window. A random
// request with a nonzero bound passes through pop, add, the bit-serial 16-bit
// remainder unit and result load; a zero bound goes from pop straight to result load.
// The input side keeps taking words into a two-entry queue while the back end works
// and while a result waits in the output register. Reset is synchronous and active
// low and needs no clearing pass.
`default_nettype none

module peak_level_meter_with_entropy_rng (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [11:0] sample_value, [27:12] random_bound
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [11:0] level, [23:12] baseline_level,
                                             // [39:24] random_value, [40] calibrating
    output logic [0:0]       m_axis_tuser,   // [0] result_kind

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [9:0]  i_cfg_data      // window_length
);

    logic [plmer_pkg::WLEN_W-1:0] r_window_length;

    logic               w_push;
    plmer_pkg::t_cmd    w_cmd;
    logic               w_q_full;
    logic               w_q_empty;
    logic               w_pop;
    plmer_pkg::t_cmd    w_head;
    logic               w_out_valid;
    plmer_pkg::t_result w_out;

    // The window length register takes a write on any cycle; the user must write it only
    // while the block is idle, and the block itself does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= plmer_pkg::WLEN_RESET;
        end else if (i_cfg_valid) begin
            r_window_length <= i_cfg_data;
        end
    end

    // Front end decodes each word and drops the unused opcode.
    plmer_front u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_opcode (s_axis_tuser),
        .i_sample (s_axis_tdata[11:0]),
        .i_bound  (s_axis_tdata[27:12]),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    plmer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    // Back end owns all measurement and generator state plus the output register.
    plmer_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_window_length (r_window_length),
        .i_q_empty       (w_q_empty),
        .i_q_head        (w_head),
        .o_q_pop         (w_pop),
        .o_out_valid     (w_out_valid),
        .i_out_ready     (m_axis_tready),
        .o_out           (w_out)
    );

    assign m_axis_tvalid   = w_out_valid;
    assign m_axis_tuser[0] = w_out.kind;
    assign m_axis_tdata    = {7'b0, w_out.calibrating, w_out.rnd, w_out.baseline, w_out.level};

`ifndef ASSERT_OFF
    // The back end never pops an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_empty))
        else $error("queue popped while empty");

    // A random result carries no level.
    a_random_no_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] == plmer_pkg::RK_RANDOM) |->
        (m_axis_tdata[11:0] == 12'd0))
        else $error("random result with nonzero level");

    // A level result carries no random number.
    a_level_no_random: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] == plmer_pkg::RK_LEVEL) |->
        (m_axis_tdata[39:24] == 16'd0))
        else $error("level result with nonzero random value");

    // Nothing is pushed into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("queue pushed while full");
`endif

endmodule

`default_nettype wire

// File: rtl/plmer_front.sv
// Front end: accepts input words and decodes them into queue commands.
// Depends on plmer_pkg.
`default_nettype none

module plmer_front (
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [plmer_pkg::OPCODE_W-1:0] i_opcode,
    input  wire logic [plmer_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [plmer_pkg::BOUND_W-1:0]  i_bound,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output plmer_pkg::t_cmd                    o_cmd
);

    logic w_known;

    assign o_ready = !i_q_full;

    // The unused opcode is accepted and dropped here.
    always_comb begin
        w_known     = 1'b1;
        o_cmd.kind  = plmer_pkg::CMD_SAMPLE;
        o_cmd.arg   = plmer_pkg::BOUND_W'(i_sample);
        unique case (i_opcode)
            plmer_pkg::OP_SAMPLE: begin
                o_cmd.kind = plmer_pkg::CMD_SAMPLE;
                o_cmd.arg  = plmer_pkg::BOUND_W'(i_sample);
            end
            plmer_pkg::OP_RANDOM: begin
                o_cmd.kind = plmer_pkg::CMD_RANDOM;
                o_cmd.arg  = i_bound;
            end
            plmer_pkg::OP_RESTART: begin
                o_cmd.kind = plmer_pkg::CMD_RESTART;
                o_cmd.arg  = '0;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && !i_q_full && w_known;

endmodule

`default_nettype wire

// File: rtl/plmer_queue.sv
// Short command queue between the front end and the back end.
// Depends on plmer_pkg.
`default_nettype none

module plmer_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire plmer_pkg::t_cmd i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output plmer_pkg::t_cmd      o_head
);

    plmer_pkg::t_cmd                 r_mem [plmer_pkg::QUEUE_DEPTH];
    logic [plmer_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [plmer_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [plmer_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == plmer_pkg::QCNT_W'(plmer_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == plmer_pkg::QPTR_W'(plmer_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == plmer_pkg::QPTR_W'(plmer_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/plmer_div.sv
// Bit-serial restoring divider that returns the remainder, one bit a cycle.
// Depends on plmer_pkg.
`default_nettype none

module plmer_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [plmer_pkg::BOUND_W-1:0] i_dividend,
    input  wire logic [plmer_pkg::BOUND_W-1:0] i_divisor,
    output logic                               o_done,
    output logic [plmer_pkg::BOUND_W-1:0]      o_remainder
);

    localparam int CNT_W = $clog2(plmer_pkg::BOUND_W + 1);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_W-1:0]               r_cnt;
    logic [plmer_pkg::BOUND_W-1:0]  r_rem;
    logic [plmer_pkg::BOUND_W-1:0]  r_quo;
    logic [plmer_pkg::BOUND_W-1:0]  r_divisor;
    logic [plmer_pkg::BOUND_W:0]    w_shift;
    logic [plmer_pkg::BOUND_W:0]    w_diff;

    // Bring down the next dividend bit and try a subtraction.
    assign w_shift = {r_rem, r_quo[plmer_pkg::BOUND_W-1]};
    assign w_diff  = w_shift - {1'b0, r_divisor};

    assign o_done      = r_done;
    assign o_remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[plmer_pkg::BOUND_W-2:0], 1'b0};
            if (!w_diff[plmer_pkg::BOUND_W]) begin
                r_rem <= w_diff[plmer_pkg::BOUND_W-1:0];
            end else begin
                r_rem <= w_shift[plmer_pkg::BOUND_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(plmer_pkg::BOUND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/plmer_back.sv
// Back end: window tracking, calibration, generator and random results.
// Depends on plmer_pkg and plmer_div.
`default_nettype none

module plmer_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [plmer_pkg::WLEN_W-1:0] i_window_length,
    input  wire logic                         i_q_empty,
    input  wire plmer_pkg::t_cmd              i_q_head,
    output logic                              o_q_pop,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output plmer_pkg::t_result                o_out
);

    localparam int SB = plmer_pkg::SAMPLE_BITS;

    plmer_pkg::t_back_state             r_state;
    plmer_pkg::t_back_state             n_state;

    logic [31:0]                        r_gen;
    logic [31:0]                        r_prod;
    logic [SB-1:0]                      r_min;
    logic [SB-1:0]                      r_max;
    logic [plmer_pkg::WLEN_W-1:0]       r_count;
    logic [plmer_pkg::CAL_SUM_W-1:0]    r_sum;
    logic [plmer_pkg::CAL_CNT_W-1:0]    r_done;
    logic                               r_cal_active;
    logic [SB-1:0]                      r_baseline;
    logic [plmer_pkg::BOUND_W-1:0]      r_arg;
    logic                               r_res_kind;
    logic [SB-1:0]                      r_res_level;
    logic [plmer_pkg::BOUND_W-1:0]      r_res_rnd;
    logic                               r_out_valid;
    plmer_pkg::t_result                 r_out;

    logic [plmer_pkg::CAL_SUM_W-1:0]    n_sum;
    logic [plmer_pkg::CAL_CNT_W-1:0]    n_done;

    logic [SB-1:0]                      w_v;
    logic [SB-1:0]                      w_head_v;
    logic [plmer_pkg::WLEN_W-1:0]       w_len;
    logic                               w_win_end;
    logic [SB-1:0]                      w_level;
    logic [31:0]                        w_gen_rnd;
    logic                               w_out_free;
    logic                               w_div_start;
    logic                               w_load_out;
    logic                               w_div_done;
    logic [plmer_pkg::BOUND_W-1:0]      w_div_rem;

    assign w_v        = r_arg[SB-1:0];
    assign w_head_v   = i_q_head.arg[SB-1:0];
    assign w_len      = (i_window_length == '0) ? plmer_pkg::WLEN_W'(1) : i_window_length;
    assign w_win_end  = (r_count == '0) || (r_count >= w_len);
    assign w_level    = r_max - r_min;
    assign w_gen_rnd  = r_prod + plmer_pkg::LCG_INC;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign n_sum  = r_sum + plmer_pkg::CAL_SUM_W'(w_level);
    assign n_done = r_done + 1'b1;

    plmer_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_gen_rnd[31:16]),
        .i_divisor   (r_arg),
        .o_done      (w_div_done),
        .o_remainder (w_div_rem)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plmer_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_head.kind)
                        plmer_pkg::CMD_SAMPLE:  n_state = plmer_pkg::BK_SMP_ADD;
                        plmer_pkg::CMD_RANDOM: begin
                            n_state = (i_q_head.arg == '0) ? plmer_pkg::BK_EMIT
                                                            : plmer_pkg::BK_RND_ADD;
                        end
                        default:                n_state = plmer_pkg::BK_IDLE;
                    endcase
                end
            end
            plmer_pkg::BK_SMP_ADD: begin
                n_state = w_win_end ? plmer_pkg::BK_EMIT : plmer_pkg::BK_IDLE;
            end
            plmer_pkg::BK_RND_ADD: n_state = plmer_pkg::BK_DIV;
            plmer_pkg::BK_DIV: begin
                n_state = w_div_done ? plmer_pkg::BK_EMIT : plmer_pkg::BK_DIV;
            end
            plmer_pkg::BK_EMIT: begin
                n_state = w_out_free ? plmer_pkg::BK_IDLE : plmer_pkg::BK_EMIT;
            end
            default: n_state = plmer_pkg::BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_q_pop     = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            plmer_pkg::BK_IDLE:    o_q_pop     = !i_q_empty;
            plmer_pkg::BK_RND_ADD: w_div_start = 1'b1;
            plmer_pkg::BK_EMIT:    w_load_out  = w_out_free;
            default: begin
            end
        endcase
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_arg  <= i_q_head.arg;
            r_prod <= r_gen * plmer_pkg::LCG_MUL;
        end
        if (r_state == plmer_pkg::BK_IDLE && o_q_pop) begin
            r_res_kind  <= plmer_pkg::RK_RANDOM;
            r_res_level <= '0;
            r_res_rnd   <= '0;
        end else if (r_state == plmer_pkg::BK_SMP_ADD) begin
            r_res_kind  <= plmer_pkg::RK_LEVEL;
            r_res_level <= w_level;
            r_res_rnd   <= '0;
        end else if (r_state == plmer_pkg::BK_DIV && w_div_done) begin
            r_res_rnd <= w_div_rem + 1'b1;
        end
        if (w_load_out) begin
            r_out.kind        <= r_res_kind;
            r_out.level       <= plmer_pkg::LEVEL_W'(r_res_level);
            r_out.baseline    <= plmer_pkg::LEVEL_W'(r_baseline);
            r_out.rnd         <= r_res_rnd;
            r_out.calibrating <= r_cal_active;
        end
    end

    // Measurement and generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= plmer_pkg::BK_IDLE;
            r_gen        <= '0;
            r_min        <= '1;
            r_max        <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_done       <= '0;
            r_cal_active <= 1'b1;
            r_baseline   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == plmer_pkg::BK_IDLE && o_q_pop) begin
                if (i_q_head.kind == plmer_pkg::CMD_SAMPLE) begin
                    if (w_head_v < r_min) r_min <= w_head_v;
                    if (w_head_v > r_max) r_max <= w_head_v;
                    r_count <= r_count + 1'b1;
                end else if (i_q_head.kind == plmer_pkg::CMD_RESTART) begin
                    r_min        <= '1;
                    r_max        <= '0;
                    r_count      <= '0;
                    r_sum        <= '0;
                    r_done       <= '0;
                    r_cal_active <= 1'b1;
                end
            end

            if (r_state == plmer_pkg::BK_SMP_ADD) begin
                r_gen <= r_prod + plmer_pkg::LCG_INC + 32'(w_v);
                if (w_win_end) begin
                    r_min   <= '1;
                    r_max   <= '0;
                    r_count <= '0;
                    if (r_cal_active) begin
                        if (n_done >= plmer_pkg::CAL_CNT_W'(plmer_pkg::CAL_WINDOWS)) begin
                            r_baseline   <= SB'(n_sum / plmer_pkg::CAL_WINDOWS);
                            r_cal_active <= 1'b0;
                            r_sum        <= '0;
                            r_done       <= '0;
                        end else begin
                            r_sum  <= n_sum;
                            r_done <= n_done;
                        end
                    end
                end
            end

            if (r_state == plmer_pkg::BK_RND_ADD) begin
                r_gen <= w_gen_rnd;
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
